### hw/rtl/bmp24p_pkg.sv
// Shared types and constants for the 24-bit BMP stream parser.
// Used by bmp24p_step and bmp24_stream_parser_unit; depends on nothing.
package bmp24p_pkg;

  // File magic characters
  localparam logic [7:0] CHAR_B = 8'h42;
  localparam logic [7:0] CHAR_M = 8'h4D;

  // Header layout: magic (2), skipped fields, then the fields that are read
  localparam int unsigned MAGIC_BYTES = 2;
  localparam int unsigned SKIP_BYTES  = 4 + 2 + 2 + 4 + 4;
  localparam int unsigned INFO_BYTES  = 4 + 4 + 4 + 4 + 4 + 4;

  // Width (4), height (4), planes (2) and depth (2) sit before the info tail
  localparam logic [5:0] OFF_WIDTH  = 6'(MAGIC_BYTES + SKIP_BYTES);
  localparam logic [5:0] OFF_HEIGHT = 6'(MAGIC_BYTES + SKIP_BYTES + 4);
  localparam logic [5:0] OFF_DEPTH  = 6'(MAGIC_BYTES + SKIP_BYTES + 10);
  localparam logic [5:0] OFF_LAST   =
    6'(MAGIC_BYTES + SKIP_BYTES + 4 + 4 + 2 + 2 + INFO_BYTES - 1);

  localparam logic [15:0] DEPTH_24   = 16'd24;
  localparam logic [16:0] DIM_RESET  = 17'd100000;

  // Configuration register indexes
  localparam logic CFG_MAX_COLUMNS = 1'b0;
  localparam logic CFG_MAX_ROWS    = 1'b1;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_HEADER    = 2'd0,
    KIND_PIXEL     = 2'd1,
    KIND_FORMAT    = 2'd2,
    KIND_TRUNCATED = 2'd3
  } kind_e;

  // Parse phase, one-hot
  typedef enum logic [5:0] {
    PH_MAGIC   = 6'b000001,
    PH_HEADER  = 6'b000010,
    PH_PIXELS  = 6'b000100,
    PH_PADDING = 6'b001000,
    PH_DONE    = 6'b010000,
    PH_FAIL    = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [16:0] column;
    logic [16:0] row;
    logic [16:0] image_width;
    logic [16:0] image_height;
    logic        last_pixel;
  } out_item_t;

  // Parser state; width/height keep 17 bits plus a flag for any higher bit set
  typedef struct packed {
    phase_e      phase;
    logic [5:0]  hdr_cnt;
    logic [16:0] width;
    logic        width_big;
    logic [16:0] height;
    logic        height_big;
    logic [15:0] depth;
    logic [16:0] col;
    logic [16:0] row;
    logic [1:0]  byte_idx;
    logic [1:0]  pad_left;
    logic [7:0]  blue;
    logic [7:0]  green;
  } parse_state_t;

  localparam parse_state_t ST_REARM = '{
    phase:      PH_MAGIC,
    hdr_cnt:    6'd0,
    width:      17'd0,
    width_big:  1'b0,
    height:     17'd0,
    height_big: 1'b0,
    depth:      16'd0,
    col:        17'd0,
    row:        17'd0,
    byte_idx:   2'd0,
    pad_left:   2'd0,
    blue:       8'd0,
    green:      8'd0
  };

endpackage

### hw/rtl/bmp24p_step.sv
// Next-state and result logic for one file byte of the BMP parser.
// Depends on bmp24p_pkg; purely combinational.
module bmp24p_step import bmp24p_pkg::*; (
  input  parse_state_t st_i,
  input  in_item_t     item_i,
  input  logic [16:0]  max_columns_i,
  input  logic [16:0]  max_rows_i,
  output parse_state_t st_o,
  output logic         res_valid_o,
  output out_item_t    res_o
);

  logic [7:0]  b;
  logic        eof;
  logic        completes;
  logic        hdr_ok;
  logic        last_col;
  logic        last_row;
  logic [7:0]  want;

  assign b   = item_i.file_byte;
  assign eof = item_i.end_of_file;

  // Header check uses the values gathered before the last header byte
  assign hdr_ok = !st_i.width_big && (st_i.width != 17'd0) && (st_i.width <= max_columns_i) &&
                  !st_i.height_big && (st_i.height != 17'd0) && (st_i.height <= max_rows_i) &&
                  (st_i.depth == DEPTH_24);

  assign last_col = ({1'b0, st_i.col} + 18'd1) >= {1'b0, st_i.width};
  assign last_row = ({1'b0, st_i.row} + 18'd1) >= {1'b0, st_i.height};
  assign want     = st_i.hdr_cnt[0] ? CHAR_M : CHAR_B;

  always_comb begin
    st_o        = st_i;
    res_o       = '0;
    res_valid_o = 1'b0;
    completes   = 1'b0;

    unique case (st_i.phase)
      // Check the two magic bytes
      PH_MAGIC: begin
        if (b != want || eof) begin
          res_o.kind  = KIND_FORMAT;
          res_valid_o = 1'b1;
          st_o.phase  = PH_FAIL;
        end else begin
          st_o.hdr_cnt = st_i.hdr_cnt + 6'd1;
          if (st_i.hdr_cnt[0]) st_o.phase = PH_HEADER;
        end
      end

      // Gather little-endian header fields, check at the last header byte
      PH_HEADER: begin
        if (st_i.hdr_cnt == OFF_WIDTH)          st_o.width[7:0]  = b;
        if (st_i.hdr_cnt == OFF_WIDTH + 6'd1)   st_o.width[15:8] = b;
        if (st_i.hdr_cnt == OFF_WIDTH + 6'd2) begin
          st_o.width[16]  = b[0];
          st_o.width_big  = st_i.width_big | (|b[7:1]);
        end
        if (st_i.hdr_cnt == OFF_WIDTH + 6'd3)   st_o.width_big = st_i.width_big | (|b);
        if (st_i.hdr_cnt == OFF_HEIGHT)         st_o.height[7:0]  = b;
        if (st_i.hdr_cnt == OFF_HEIGHT + 6'd1)  st_o.height[15:8] = b;
        if (st_i.hdr_cnt == OFF_HEIGHT + 6'd2) begin
          st_o.height[16] = b[0];
          st_o.height_big = st_i.height_big | (|b[7:1]);
        end
        if (st_i.hdr_cnt == OFF_HEIGHT + 6'd3)  st_o.height_big = st_i.height_big | (|b);
        if (st_i.hdr_cnt == OFF_DEPTH)          st_o.depth[7:0]  = b;
        if (st_i.hdr_cnt == OFF_DEPTH + 6'd1)   st_o.depth[15:8] = b;

        if (st_i.hdr_cnt >= OFF_LAST) begin
          res_valid_o = 1'b1;
          if (!hdr_ok) begin
            res_o.kind = KIND_FORMAT;
            st_o.phase = PH_FAIL;
          end else begin
            res_o.kind         = eof ? KIND_TRUNCATED : KIND_HEADER;
            res_o.image_width  = st_i.width;
            res_o.image_height = st_i.height;
            st_o.phase         = PH_PIXELS;
            st_o.col           = 17'd0;
            st_o.row           = 17'd0;
            st_o.byte_idx      = 2'd0;
            st_o.pad_left      = 2'd0;
          end
        end else begin
          if (eof) begin
            res_o.kind  = KIND_FORMAT;
            res_valid_o = 1'b1;
            st_o.phase  = PH_FAIL;
          end
          st_o.hdr_cnt = st_i.hdr_cnt + 6'd1;
        end
      end

      // Hold blue and green, emit a pixel on red
      PH_PIXELS: begin
        unique case (st_i.byte_idx)
          2'd0: begin
            st_o.blue     = b;
            st_o.byte_idx = 2'd1;
          end
          2'd1: begin
            st_o.green    = b;
            st_o.byte_idx = 2'd2;
          end
          default: begin
            res_valid_o        = 1'b1;
            res_o.kind         = KIND_PIXEL;
            res_o.red          = b;
            res_o.green        = st_i.green;
            res_o.blue         = st_i.blue;
            res_o.column       = st_i.col;
            res_o.row          = st_i.row;
            res_o.image_width  = st_i.width;
            res_o.image_height = st_i.height;
            res_o.last_pixel   = last_col && last_row;
            st_o.byte_idx      = 2'd0;
            if (last_col) begin
              st_o.col = 17'd0;
              st_o.row = st_i.row + 17'd1;
              if (st_i.width[1:0] != 2'd0) begin
                st_o.pad_left = st_i.width[1:0];
                st_o.phase    = PH_PADDING;
              end else if (last_row) begin
                st_o.phase = PH_DONE;
                completes  = 1'b1;
              end
            end else begin
              st_o.col = st_i.col + 17'd1;
            end
          end
        endcase
      end

      // Drop row padding
      PH_PADDING: begin
        st_o.pad_left = st_i.pad_left - 2'd1;
        if (st_i.pad_left == 2'd1) begin
          if (st_i.row >= st_i.height) begin
            st_o.phase = PH_DONE;
            completes  = 1'b1;
          end else begin
            st_o.phase = PH_PIXELS;
          end
        end
      end

      // Ignore bytes until the end flag
      PH_DONE, PH_FAIL: begin
      end

      default: begin
      end
    endcase

    // End flag inside the image replaces this byte's result
    if (eof && !completes && (st_o.phase == PH_PIXELS || st_o.phase == PH_PADDING)) begin
      res_o              = '0;
      res_o.kind         = KIND_TRUNCATED;
      res_o.image_width  = st_i.width;
      res_o.image_height = st_i.height;
      res_valid_o        = 1'b1;
    end

    // Rearm after the last byte of a file
    if (eof) st_o = ST_REARM;
  end

endmodule

### hw/rtl/bmp24_stream_parser_unit.sv
// Top level of the 24-bit BMP stream parser: handshakes, config, state, result.
// Depends on bmp24p_pkg and bmp24p_step.
//
//  port group   dir  handshake            word
//  in_*         in   valid / stall        one file byte plus end flag
//  out_*        out  valid / stall        one header, pixel or error result
//  cfg_*        in   valid / ready        register index plus 17-bit value
//
// One file byte per cycle while in_stall_o is low: each word goes through the
// step logic into the state register and, when it yields a result, into the
// output register or skid entry; the two-entry output keeps input flowing
// while out_stall_i is high for a cycle; input stalls only while the skid entry
// is full. Reset puts the parser at the magic bytes and both limits at 100000.
module bmp24_stream_parser_unit import bmp24p_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  logic [16:0]  max_columns_q;
  logic [16:0]  max_rows_q;
  parse_state_t st_q, st_d;
  logic         res_valid;
  out_item_t    res;
  out_item_t    out_q;
  out_item_t    skid_q;
  logic         out_valid_q;
  logic         skid_valid_q;
  logic         in_take;
  logic         out_take;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_take     = in_valid_i && !skid_valid_q;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Write limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_columns_q <= DIM_RESET;
      max_rows_q    <= DIM_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_COLUMNS: max_columns_q <= cfg_data_i;
        CFG_MAX_ROWS:    max_rows_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  bmp24p_step u_step (
    .st_i          (st_q),
    .item_i        (in_data_i),
    .max_columns_i (max_columns_q),
    .max_rows_i    (max_rows_q),
    .st_o          (st_d),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // Advance parser state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_REARM;
    end else if (in_take) begin
      st_q <= st_d;
    end
  end

  // Output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) skid_valid_q <= 1'b0;
    end else if (in_take && res_valid) begin
      if (out_valid_q && !out_take) skid_valid_q <= 1'b1;
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) out_q <= skid_q;
    end else if (in_take && res_valid) begin
      if (out_valid_q && !out_take) skid_q <= res;
      else                          out_q  <= res;
    end
  end

  // Skid entry is only used behind a held output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry full with empty output register");

  // End flag rearms the parser
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && in_data_i.end_of_file) |=> (st_q.phase == PH_MAGIC && st_q.hdr_cnt == 6'd0))
    else $error("parser not rearmed after end of file");

  // Pixel phases only run with an accepted, nonzero image size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == PH_PIXELS || st_q.phase == PH_PADDING) |->
      (st_q.width != 17'd0 && st_q.height != 17'd0))
    else $error("pixel phase with zero image size");

  // Color byte index stays within blue, green, red
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.byte_idx != 2'd3)
    else $error("pixel byte index out of range");

endmodule
